// ----- rtl/core/qtv_pkg.sv -----
// Shared types and constants of the quintic trajectory velocity generator.
package qtv_pkg;

  localparam int TIME_W  = 32;
  localparam int COEF_W  = 32;
  localparam int DUR_W   = 24;
  localparam int TOT_W   = 26;
  localparam int TWO_W   = 27;
  localparam int ACC_W   = 39;
  localparam int PROD_W  = 64;
  localparam int VEL_W   = 32;
  localparam int VEL_FIELDS = 6;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_EVAL = 1'b1;

  localparam logic [1:0] REG_DUR0 = 2'd0;
  localparam logic [1:0] REG_DUR1 = 2'd1;
  localparam logic [1:0] REG_DUR2 = 2'd2;
  localparam logic [1:0] REG_DUR3 = 2'd3;

  localparam logic [DUR_W-1:0] DUR0_RST = 24'd294912;
  localparam logic [DUR_W-1:0] DUR1_RST = 24'd98304;
  localparam logic [DUR_W-1:0] DUR2_RST = 24'd78643;
  localparam logic [DUR_W-1:0] DUR3_RST = 24'd131072;

  // Operations of the shared multiply-accumulate unit.
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_INIT = 2'd1;
  localparam logic [1:0] OP_MLO  = 2'd2;
  localparam logic [1:0] OP_MHI  = 2'd3;

  typedef struct packed {
    logic                     kind;
    logic [7:0]               coef_index;
    logic signed [COEF_W-1:0] coef_value;
    logic [TIME_W-1:0]        abs_time;
  } in_item_t;

  typedef struct packed {
    logic signed [VEL_W-1:0] vel_j0;
    logic signed [VEL_W-1:0] vel_j1;
    logic signed [VEL_W-1:0] vel_j2;
    logic signed [VEL_W-1:0] vel_j3;
    logic signed [VEL_W-1:0] vel_j4;
    logic signed [VEL_W-1:0] vel_j5;
    logic [1:0]              segment;
    logic                    reversed;
  } out_item_t;

  typedef struct packed {
    logic [1:0] op;
    logic       add;
    logic [2:0] k;
  } mac_ctl_t;

endpackage

// ----- rtl/core/qtv_coef_ram.sv -----
// Coefficient memory: one write port, one registered read port.
module qtv_coef_ram #(
  parameter int DEPTH  = 144,
  parameter int ADDR_W = 8
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [ADDR_W-1:0]                waddr,
  input  logic signed [qtv_pkg::COEF_W-1:0] wdata,
  input  logic [ADDR_W-1:0]                raddr,
  output logic signed [qtv_pkg::COEF_W-1:0] rdata
);

  logic signed [qtv_pkg::COEF_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/qtv_mod_unit.sv -----
// Restoring remainder unit, one dividend bit per cycle.
module qtv_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [qtv_pkg::TIME_W-1:0]  dividend,
  input  logic [qtv_pkg::TWO_W-1:0]   divisor,
  output logic                        done,
  output logic [qtv_pkg::TWO_W-1:0]   rem
);

  logic [qtv_pkg::TIME_W-1:0] dvd;
  logic [qtv_pkg::TWO_W-1:0]  dsr;
  logic [5:0]                 cnt;
  logic [qtv_pkg::TWO_W:0]    trial;

  always_comb begin
    trial = {rem, dvd[qtv_pkg::TIME_W-1]};
    if (trial >= {1'b0, dsr}) begin
      trial = trial - {1'b0, dsr};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        cnt <= 6'(qtv_pkg::TIME_W);
      end else if (cnt != '0) begin
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (cnt != '0) begin
      dvd <= {dvd[qtv_pkg::TIME_W-2:0], 1'b0};
      rem <= trial[qtv_pkg::TWO_W-1:0];
    end
  end

endmodule

// ----- rtl/core/qtv_mac_unit.sv -----
// Shared Horner step unit: split multiply, rounding shift, scaled add, saturation.
module qtv_mac_unit (
  input  logic                               clk,
  input  qtv_pkg::mac_ctl_t                  ctl,
  input  logic signed [qtv_pkg::COEF_W-1:0]  coef,
  input  logic [qtv_pkg::TIME_W-1:0]         tau,
  output logic signed [qtv_pkg::ACC_W-1:0]   acc
);

  localparam logic signed [48:0] ACC_MAX = 49'sd274877906943;
  localparam logic signed [48:0] ACC_MIN = -49'sd274877906944;

  logic signed [qtv_pkg::PROD_W-1:0] prod;
  logic [15:0]                       half;
  logic signed [55:0]                mp;
  logic signed [qtv_pkg::PROD_W-1:0] mp_ext;
  logic signed [qtv_pkg::PROD_W-1:0] q;
  logic signed [35:0]                kc;
  logic signed [48:0]                sum;
  logic signed [qtv_pkg::ACC_W-1:0]  sat;

  always_comb begin
    half   = (ctl.op == qtv_pkg::OP_MHI) ? tau[31:16] : tau[15:0];
    mp     = acc * $signed({1'b0, half});
    mp_ext = {{(qtv_pkg::PROD_W-56){mp[55]}}, mp};
    kc     = coef * $signed({1'b0, ctl.k});
    // Round half up, then arithmetic shift by the 16 fraction bits of tau.
    q      = prod + 64'sd32768;
    sum    = {q[63], q[63:16]} + {{13{kc[35]}}, kc};
    if (sum > ACC_MAX) begin
      sat = ACC_MAX[qtv_pkg::ACC_W-1:0];
    end else if (sum < ACC_MIN) begin
      sat = ACC_MIN[qtv_pkg::ACC_W-1:0];
    end else begin
      sat = sum[qtv_pkg::ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      qtv_pkg::OP_INIT: begin
        if (ctl.add) begin
          acc <= sat;
        end else begin
          acc <= {{(qtv_pkg::ACC_W-36){kc[35]}}, kc};
        end
      end
      qtv_pkg::OP_MLO: prod <= mp_ext;
      qtv_pkg::OP_MHI: prod <= prod + {mp_ext[qtv_pkg::PROD_W-17:0], 16'b0};
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/core/quintic_trajectory_velocity.sv -----
// An evaluate command past the lead-in segment first passes RED, MOD (only when the
// remainder unit folds the time), VSEL and SRCH. Then each of NJ joints passes RD, INIT,
// one MLO, MHI, ADD Horner step per remaining coefficient, and FIN; NJ is the smaller of
// JOINTS and 6. The shared multiply-accumulate unit does the Horner steps; busy falls
// with done, so the next command can transfer at the edge that ends the done cycle.
// Loads leave the block idle and give no result. Synchronous reset restores durations, not coefficients.
module quintic_trajectory_velocity #(
  parameter int JOINTS   = 6,
  parameter int SEGMENTS = 4,
  parameter int COEFS    = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  qtv_pkg::in_item_t           cmd,
  output logic                        done,
  output qtv_pkg::out_item_t          result,
  input  logic                        cfg_we,
  input  logic [1:0]                  cfg_index,
  input  logic [qtv_pkg::DUR_W-1:0]   cfg_data
);

  localparam int DEPTH  = JOINTS * SEGMENTS * COEFS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int NJ     = (JOINTS < qtv_pkg::VEL_FIELDS) ? JOINTS : qtv_pkg::VEL_FIELDS;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_RED  = 4'd1;
  localparam logic [3:0] ST_MOD  = 4'd2;
  localparam logic [3:0] ST_VSEL = 4'd3;
  localparam logic [3:0] ST_SRCH = 4'd4;
  localparam logic [3:0] ST_RD   = 4'd5;
  localparam logic [3:0] ST_INIT = 4'd6;
  localparam logic [3:0] ST_MLO  = 4'd7;
  localparam logic [3:0] ST_MHI  = 4'd8;
  localparam logic [3:0] ST_ADD  = 4'd9;
  localparam logic [3:0] ST_FIN  = 4'd10;

  logic [3:0]                 state;
  logic [qtv_pkg::DUR_W-1:0]  dur0, dur1, dur2, dur3;
  logic [qtv_pkg::TIME_W-1:0] u;
  logic [qtv_pkg::TOT_W-1:0]  tot;
  logic [qtv_pkg::TWO_W-1:0]  two;
  logic [qtv_pkg::TWO_W-1:0]  v;
  logic [qtv_pkg::TIME_W-1:0] tau;
  logic [1:0]                 seg;
  logic                       rev;
  logic [2:0]                 joint;
  logic [2:0]                 order;
  logic signed [qtv_pkg::VEL_W-1:0] vel [qtv_pkg::VEL_FIELDS];

  logic accept;
  logic mod_start, mod_done;
  logic [qtv_pkg::TWO_W-1:0] mod_rem;
  logic [qtv_pkg::TOT_W-1:0] tot_in;
  logic [qtv_pkg::TWO_W-1:0] s2, s3;
  logic                      seg_ok;
  logic [ADDR_W-1:0]         raddr;
  logic signed [qtv_pkg::COEF_W-1:0] rdata, coef;
  logic                      ram_we;
  qtv_pkg::mac_ctl_t         ctl;
  logic signed [qtv_pkg::ACC_W-1:0] acc;
  logic signed [qtv_pkg::ACC_W:0]   vneg;
  logic signed [qtv_pkg::VEL_W-1:0] vsat;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;
  assign ram_we = accept && (cmd.kind == qtv_pkg::KIND_LOAD) && (int'(cmd.coef_index) < DEPTH);
  assign tot_in = {2'b0, dur1} + {2'b0, dur2} + {2'b0, dur3};
  assign mod_start = (state == ST_RED) && (two != '0) && ({5'b0, two} < u);
  assign s2 = {3'b0, dur1};
  assign s3 = {3'b0, dur1} + {3'b0, dur2};
  assign seg_ok = int'(seg) < SEGMENTS;
  assign raddr  = seg_ok ? ADDR_W'((int'(joint) * SEGMENTS + int'(seg)) * COEFS + int'(order))
                         : '0;
  assign coef   = seg_ok ? rdata : '0;

  always_comb begin
    ctl.op  = qtv_pkg::OP_NONE;
    ctl.add = 1'b0;
    ctl.k   = order;
    case (state)
      ST_INIT: begin
        ctl.op = qtv_pkg::OP_INIT;
        ctl.k  = 3'(COEFS - 1);
      end
      ST_MLO: ctl.op = qtv_pkg::OP_MLO;
      ST_MHI: ctl.op = qtv_pkg::OP_MHI;
      ST_ADD: begin
        // The add step reuses the load path of the accumulator with saturation.
        ctl.op  = qtv_pkg::OP_INIT;
        ctl.add = 1'b1;
      end
      default: ctl.op = qtv_pkg::OP_NONE;
    endcase
    vneg = rev ? -{acc[qtv_pkg::ACC_W-1], acc} : {acc[qtv_pkg::ACC_W-1], acc};
    if (vneg > 40'sd2147483647) begin
      vsat = 32'sh7fffffff;
    end else if (vneg < -40'sd2147483648) begin
      vsat = 32'sh80000000;
    end else begin
      vsat = vneg[qtv_pkg::VEL_W-1:0];
    end
  end

  qtv_coef_ram #(
    .DEPTH (DEPTH),
    .ADDR_W(ADDR_W)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ADDR_W'(cmd.coef_index)),
    .wdata(cmd.coef_value),
    .raddr(raddr),
    .rdata(rdata)
  );

  qtv_mod_unit u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (mod_start),
    .dividend(u),
    .divisor (two),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  qtv_mac_unit u_mac (
    .clk (clk),
    .ctl (ctl),
    .coef(coef),
    .tau (tau),
    .acc (acc)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dur0 <= qtv_pkg::DUR0_RST;
      dur1 <= qtv_pkg::DUR1_RST;
      dur2 <= qtv_pkg::DUR2_RST;
      dur3 <= qtv_pkg::DUR3_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        qtv_pkg::REG_DUR0: dur0 <= cfg_data;
        qtv_pkg::REG_DUR1: dur1 <= cfg_data;
        qtv_pkg::REG_DUR2: dur2 <= cfg_data;
        qtv_pkg::REG_DUR3: dur3 <= cfg_data;
        default: dur0 <= dur0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept && (cmd.kind == qtv_pkg::KIND_EVAL)) begin
            state <= (cmd.abs_time < {8'b0, dur0}) ? ST_RD : ST_RED;
          end
        end
        ST_RED:  state <= mod_start ? ST_MOD : ST_VSEL;
        ST_MOD:  state <= mod_done ? ST_VSEL : ST_MOD;
        ST_VSEL: state <= ST_SRCH;
        ST_SRCH: state <= ST_RD;
        ST_RD:   state <= ST_INIT;
        ST_INIT: state <= (COEFS > 2) ? ST_MLO : ST_FIN;
        ST_MLO:  state <= ST_MHI;
        ST_MHI:  state <= ST_ADD;
        ST_ADD:  state <= (order == 3'd1) ? ST_FIN : ST_MLO;
        ST_FIN: begin
          if (int'(joint) == NJ - 1) begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end else begin
            state <= ST_RD;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        u     <= cmd.abs_time - {8'b0, dur0};
        tot   <= tot_in;
        two   <= {tot_in, 1'b0};
        tau   <= cmd.abs_time;
        seg   <= 2'd0;
        rev   <= 1'b0;
        joint <= '0;
        order <= 3'(COEFS - 1);
      end
      ST_MOD: begin
        if (mod_done) begin
          // An exact multiple of the round trip folds onto its end, not zero.
          u <= (mod_rem == '0) ? {5'b0, two} : {5'b0, mod_rem};
        end
      end
      ST_VSEL: begin
        if (u < {6'b0, tot}) begin
          v <= u[qtv_pkg::TWO_W-1:0];
        end else begin
          rev <= 1'b1;
          v   <= (u >= {5'b0, two}) ? '0 : two - u[qtv_pkg::TWO_W-1:0];
        end
      end
      ST_SRCH: begin
        if (v < {3'b0, dur1}) begin
          seg <= 2'd1;
          tau <= {5'b0, v};
        end else if (v < s3) begin
          seg <= 2'd2;
          tau <= {5'b0, v - s2};
        end else begin
          // Segment 3 also takes the exact end of the cycle.
          seg <= 2'd3;
          tau <= {5'b0, v - s3};
        end
      end
      ST_INIT: order <= 3'(COEFS - 2);
      ST_ADD:  order <= order - 3'd1;
      ST_FIN: begin
        vel[joint] <= vsat;
        joint      <= joint + 3'd1;
        order      <= 3'(COEFS - 1);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result.vel_j0   = (JOINTS > 0) ? vel[0] : '0;
    result.vel_j1   = (JOINTS > 1) ? vel[1] : '0;
    result.vel_j2   = (JOINTS > 2) ? vel[2] : '0;
    result.vel_j3   = (JOINTS > 3) ? vel[3] : '0;
    result.vel_j4   = (JOINTS > 4) ? vel[4] : '0;
    result.vel_j5   = (JOINTS > 5) ? vel[5] : '0;
    result.segment  = seg;
    result.reversed = rev;
  end

endmodule

// ----- rtl/core/qtv_checker.sv -----
// Port-level checks of the velocity generator and their attachment.
module qtv_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic kind
);

  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done strobe while busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done strobe longer than one cycle");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && kind) |=> busy)
    else $error("evaluate transfer did not make the block busy");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !kind) |=> (!busy && !done))
    else $error("load transfer started work or gave a result");

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("done strobe without preceding work");

endmodule

bind quintic_trajectory_velocity qtv_checker u_qtv_checker (
  .clk  (clk),
  .rst  (rst),
  .start(start),
  .busy (busy),
  .done (done),
  .kind (cmd.kind)
);

// ----- tb/tb_top.sv -----
// Testbench for the quintic trajectory velocity generator: random commands, scoreboard.
module tb_top;

  localparam int NSLOT = 144;
  localparam int SETTLE = 200;
  localparam longint LIMIT = 3000000;
  localparam longint ACC_HI = 64'sd274877906943;
  localparam longint ACC_LO = -64'sd274877906944;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  qtv_pkg::in_item_t cmd = '0;
  logic done;
  qtv_pkg::out_item_t result;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = qtv_pkg::REG_DUR0;
  logic [qtv_pkg::DUR_W-1:0] cfg_data = '0;

  quintic_trajectory_velocity DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of durations and coefficients.
  logic [qtv_pkg::DUR_W-1:0] seg_len [4];
  logic signed [31:0] coefs [NSLOT];

  qtv_pkg::in_item_t pending_cmds[$];
  qtv_pkg::out_item_t expected_vel[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_off = 1'b0;
  int burst_left = 0;
  int gap_left = 0;

  function automatic void add_cmd(qtv_pkg::in_item_t c);
    pending_cmds = {pending_cmds, c};
  endfunction

  function automatic longint round16(longint p);
    longint q;
    q = p + 32768;
    return q >>> 16;
  endfunction

  function automatic logic signed [31:0] joint_rate(int j, int sg, longint tau, bit rev);
    longint acc;
    int base;
    base = (j * 4 + sg) * 6;
    acc = 5 * longint'(coefs[base + 5]);
    for (int k = 4; k >= 1; k--) begin
      acc = round16(acc * tau) + k * longint'(coefs[base + k]);
      if (acc > ACC_HI) acc = ACC_HI;
      if (acc < ACC_LO) acc = ACC_LO;
    end
    if (rev) acc = -acc;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  function automatic qtv_pkg::out_item_t velocity_at(logic [31:0] t);
    qtv_pkg::out_item_t r;
    longint u, v, tot, two, tau, s2, s3;
    int sg;
    bit rev;
    rev = 1'b0;
    if (t < seg_len[0]) begin
      sg = 0;
      tau = t;
    end else begin
      u = longint'(t) - seg_len[0];
      tot = longint'(seg_len[1]) + seg_len[2] + seg_len[3];
      two = tot * 2;
      if (two > 0 && u > two) begin
        u = u % two;
        if (u == 0) u = two;
      end
      if (u < tot) v = u;
      else begin
        rev = 1'b1;
        v = (u >= two) ? 0 : two - u;
      end
      s2 = seg_len[1];
      s3 = s2 + seg_len[2];
      // The exact end of the cycle matches no interval and falls to segment 3.
      sg = 3;
      tau = (v >= s3) ? v - s3 : 0;
      if (v < s2) begin
        sg = 1; tau = v;
      end else if (v < s3) begin
        sg = 2; tau = v - s2;
      end else if (v < s3 + seg_len[3]) begin
        sg = 3; tau = v - s3;
      end
    end
    r.vel_j0 = joint_rate(0, sg, tau, rev);
    r.vel_j1 = joint_rate(1, sg, tau, rev);
    r.vel_j2 = joint_rate(2, sg, tau, rev);
    r.vel_j3 = joint_rate(3, sg, tau, rev);
    r.vel_j4 = joint_rate(4, sg, tau, rev);
    r.vel_j5 = joint_rate(5, sg, tau, rev);
    r.segment = sg[1:0];
    r.reversed = rev;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  function automatic qtv_pkg::in_item_t load_cmd(int idx, logic [31:0] val);
    qtv_pkg::in_item_t c;
    c = '0;
    c.kind = qtv_pkg::KIND_LOAD;
    c.coef_index = idx[7:0];
    c.coef_value = val;
    c.abs_time = $urandom;
    return c;
  endfunction

  function automatic qtv_pkg::in_item_t eval_cmd(logic [31:0] t);
    qtv_pkg::in_item_t c;
    c.kind = qtv_pkg::KIND_EVAL;
    c.coef_index = 8'($urandom);
    c.coef_value = $urandom;
    c.abs_time = t;
    return c;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 32'h00ffffff);
      3: return -$urandom_range(0, 32'h00ffffff);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    longint tot;
    longint r;
    tot = longint'(seg_len[1]) + seg_len[2] + seg_len[3];
    case ($urandom_range(0, 6))
      0: r = $urandom;
      1: r = $urandom_range(0, 32'(seg_len[0]));
      2: r = seg_len[0] + tot;
      3: r = seg_len[0] + 2 * tot * $urandom_range(1, 4);
      4: r = longint'(seg_len[0]) + seg_len[1] + seg_len[2];
      default: r = seg_len[0] + $urandom_range(0, 32'(3 * tot));
    endcase
    return 32'(r);
  endfunction

  // Driver: bursts with random gaps; the predictor runs at the accepting edge.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (start && !busy) begin
        if (cmd.kind == qtv_pkg::KIND_LOAD) begin
          if (cmd.coef_index < NSLOT) begin
            coefs[cmd.coef_index] = cmd.coef_value;
          end
        end else begin
          expected_vel = {expected_vel, velocity_at(cmd.abs_time)};
        end
      end
      if (start && busy) begin
        // Keep offering the same command.
      end else if (pending_cmds.size() > 0 && !hold_off && gap_left == 0) begin
        start <= 1'b1;
        cmd <= pending_cmds.pop_front();
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 40);
        end else burst_left--;
      end else begin
        start <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked.
  always @(posedge clk) begin
    qtv_pkg::out_item_t w;
    if (!rst && done) begin
      if (expected_vel.size() == 0) begin
        report("unexpected result", result.segment, -1);
      end else begin
        w = expected_vel.pop_front();
        if (result.vel_j0 !== w.vel_j0) report("vel_j0", result.vel_j0, w.vel_j0);
        if (result.vel_j1 !== w.vel_j1) report("vel_j1", result.vel_j1, w.vel_j1);
        if (result.vel_j2 !== w.vel_j2) report("vel_j2", result.vel_j2, w.vel_j2);
        if (result.vel_j3 !== w.vel_j3) report("vel_j3", result.vel_j3, w.vel_j3);
        if (result.vel_j4 !== w.vel_j4) report("vel_j4", result.vel_j4, w.vel_j4);
        if (result.vel_j5 !== w.vel_j5) report("vel_j5", result.vel_j5, w.vel_j5);
        if (result.segment !== w.segment) report("segment", result.segment, w.segment);
        if (result.reversed !== w.reversed) report("reversed", result.reversed, w.reversed);
      end
    end
    if (cycles > LIMIT) begin
      $display("timeout at cycle %0d", cycles);
      $display("FAIL");
      $finish;
    end
  end

  task automatic drain();
    while (pending_cmds.size() > 0 || start || busy || expected_vel.size() > 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_len(logic [1:0] idx, logic [qtv_pkg::DUR_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    seg_len[idx] = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_random(int n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) == 0)
        add_cmd(load_cmd($urandom_range(0, 255), rand_coef()));
      else add_cmd(eval_cmd(rand_time()));
    end
  endtask

  task automatic random_phase(int n);
    queue_random(n);
    drain();
  endtask

  initial begin
    int k;
    seg_len[0] = qtv_pkg::DUR0_RST;
    seg_len[1] = qtv_pkg::DUR1_RST;
    seg_len[2] = qtv_pkg::DUR2_RST;
    seg_len[3] = qtv_pkg::DUR3_RST;
    for (int i = 0; i < NSLOT; i++) begin
      coefs[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Fill the whole store first so that no evaluation reads an unwritten slot.
    for (int i = 0; i < NSLOT; i++) add_cmd(load_cmd(i, rand_coef()));
    add_cmd(load_cmd(0, 32'h7fffffff));
    add_cmd(load_cmd(5, 32'h80000000));
    add_cmd(load_cmd(200, 32'h12345678));
    add_cmd(load_cmd(255, 32'hffffffff));
    add_cmd(eval_cmd(32'd0));
    add_cmd(eval_cmd(qtv_pkg::DUR0_RST - 1));
    add_cmd(eval_cmd(qtv_pkg::DUR0_RST));
    add_cmd(eval_cmd(qtv_pkg::DUR0_RST + qtv_pkg::DUR1_RST));
    add_cmd(eval_cmd(qtv_pkg::DUR0_RST + qtv_pkg::DUR1_RST + qtv_pkg::DUR2_RST +
                     qtv_pkg::DUR3_RST));
    add_cmd(eval_cmd(qtv_pkg::DUR0_RST +
                     2 * (qtv_pkg::DUR1_RST + qtv_pkg::DUR2_RST + qtv_pkg::DUR3_RST)));
    add_cmd(eval_cmd(32'hffffffff));
    add_cmd(eval_cmd(32'h80000000));
    drain();

    random_phase(80);

    // Pause the sender mid-stream until every evaluation has reported, then carry on.
    queue_random(30);
    while (pending_cmds.size() > 15) @(posedge clk);
    hold_off = 1'b1;
    while (start || busy || expected_vel.size() > 0) @(posedge clk);
    hold_off = 1'b0;
    drain();

    set_len(qtv_pkg::REG_DUR0, 24'hffffff);
    set_len(qtv_pkg::REG_DUR1, 24'hffffff);
    set_len(qtv_pkg::REG_DUR2, 24'hffffff);
    set_len(qtv_pkg::REG_DUR3, 24'hffffff);
    random_phase(90);
    set_len(qtv_pkg::REG_DUR0, 24'd1);
    set_len(qtv_pkg::REG_DUR1, 24'd1);
    set_len(qtv_pkg::REG_DUR2, 24'd1);
    set_len(qtv_pkg::REG_DUR3, 24'd1);
    random_phase(90);
    for (k = 0; k < 2; k++) begin
      set_len(qtv_pkg::REG_DUR0, 24'($urandom_range(1, 24'hffffff)));
      set_len(qtv_pkg::REG_DUR1, 24'($urandom_range(1, 24'h03ffff)));
      set_len(qtv_pkg::REG_DUR2, 24'($urandom_range(1, 24'h03ffff)));
      set_len(qtv_pkg::REG_DUR3, 24'($urandom_range(1, 24'h03ffff)));
      random_phase(55);
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
